// ===== rtl/core/timestamp_time_base_rescaler_unit_defines.svh =====
// Assertion macros for the timestamp rescaler
`ifndef TIMESTAMP_TIME_BASE_RESCALER_UNIT_DEFINES_SVH
`define TIMESTAMP_TIME_BASE_RESCALER_UNIT_DEFINES_SVH

// same-cycle implication
`define TSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tsr_pkg.sv =====
// Shared types, constants and helpers for the timestamp rescaler
package tsr_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int DATA_W      = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STEPS   = 64;
    localparam int DCNT_W      = 7;
    localparam int MCNT_W      = 3;
    localparam int GK_W        = 7;
    localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(4);
    localparam logic [MCNT_W-1:0] MUL_DONE = MCNT_W'(5);
    localparam logic [DATA_W-1:0] VAL_LIM  = DATA_W'(1) << (VALUE_WIDTH - 1);
    localparam logic [DATA_W-1:0] MAG_LIM  = DATA_W'(1) << (DATA_W - 1);

    typedef enum logic [2:0] {
        ST_OK,
        ST_ZERO_TARGET,
        ST_MUL_OVF,
        ST_DIV_OVF,
        ST_QUOT_WIDE,
        ST_ROUND_OVF,
        ST_SIGNED_OVF
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_NUM,
        REG_SRC_DEN,
        REG_TGT_NUM,
        REG_TGT_DEN,
        REG_ROUND_MODE
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RND_ZERO,
        RND_DOWN,
        RND_UP,
        RND_NEAREST
    } round_t;

    typedef enum logic [3:0] {
        STEP_GCD_NUM,
        STEP_GCD_DEN,
        STEP_DIV_SN,
        STEP_DIV_TN,
        STEP_DIV_SD,
        STEP_DIV_TD,
        STEP_MUL_M,
        STEP_MUL_D,
        STEP_MUL_P,
        STEP_DIV_Q
    } step_t;

    typedef enum logic [1:0] {
        UNIT_GCD,
        UNIT_DIV,
        UNIT_MUL
    } unit_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_START,
        OP_STEP,
        OP_WB,
        OP_FIN,
        OP_ERR,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_RUN,
        S_EVAL,
        S_FIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t     op;
        step_t   step;
        status_t code;
    } tsr_cmd_t;

    typedef struct packed {
        logic done;
        logic zero_tgt;
        logic zero_src;
        logic chk_ovf;
        logic quot_wide;
    } tsr_stat_t;

    function automatic unit_t step_unit(input step_t s);
        unit_t u;
        case (s) inside
            STEP_GCD_NUM, STEP_GCD_DEN:                    u = UNIT_GCD;
            STEP_MUL_M, STEP_MUL_D, STEP_MUL_P:            u = UNIT_MUL;
            default:                                       u = UNIT_DIV;
        endcase
        return u;
    endfunction

    function automatic logic [DATA_W-1:0] sext_value(input logic [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] t;
        t = $signed(x << (DATA_W - VALUE_WIDTH));
        return $unsigned(t >>> (DATA_W - VALUE_WIDTH));
    endfunction

    function automatic logic [DATA_W-1:0] abs_mag(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

endpackage

// ===== rtl/core/tsr_ctrl.sv =====
// Sequencing state machine for the timestamp rescaler
module tsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tsr_pkg::tsr_stat_t  stat,
    output tsr_pkg::tsr_cmd_t   cmd
);
    import tsr_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    logic   step_err;

    always_comb
    begin
        case (step_reg)
            STEP_MUL_M: step_err = stat.chk_ovf;
            STEP_MUL_D: step_err = stat.chk_ovf;
            STEP_MUL_P: step_err = stat.quot_wide;
            default:    step_err = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_GCD_NUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                step_next = STEP_GCD_NUM;
                if (stat.zero_tgt || stat.zero_src)
                    state_next = S_EMIT;
                else
                    state_next = S_START;
            end
            S_START: state_next = S_RUN;
            S_RUN:
            begin
                if (stat.done)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (step_err)
                    state_next = S_EMIT;
                else if (step_reg == STEP_DIV_Q)
                    state_next = S_FIN;
                else
                begin
                    step_next  = step_t'(step_reg + 4'd1);
                    state_next = S_START;
                end
            end
            S_FIN: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op         = OP_IDLE;
        cmd.step       = step_reg;
        cmd.code       = ST_OK;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            S_CHECK:
            begin
                if (stat.zero_tgt)
                begin
                    cmd.op   = OP_ERR;
                    cmd.code = ST_ZERO_TARGET;
                end
                else if (stat.zero_src)
                begin
                    cmd.op   = OP_ERR;
                    cmd.code = ST_OK;
                end
            end
            S_START: cmd.op = OP_START;
            S_RUN:   cmd.op = OP_STEP;
            S_EVAL:
            begin
                if (step_err)
                begin
                    cmd.op = OP_ERR;
                    case (step_reg)
                        STEP_MUL_M: cmd.code = ST_MUL_OVF;
                        STEP_MUL_D: cmd.code = ST_DIV_OVF;
                        default:    cmd.code = ST_QUOT_WIDE;
                    endcase
                end
                else
                    cmd.op = OP_WB;
            end
            S_FIN: cmd.op = OP_FIN;
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd.op = OP_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/tsr_datapath.sv =====
// Registers, gcd, multiply and divide units of the timestamp rescaler
module tsr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsr_pkg::tsr_cmd_t             cmd,
    output tsr_pkg::tsr_stat_t            stat,
    input  logic [tsr_pkg::DATA_W-1:0]    stamp_in,
    input  logic                          cfg_we,
    input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsr_pkg::DATA_W-1:0]    cfg_data,
    output logic [tsr_pkg::DATA_W-1:0]    stamp_out,
    output logic [2:0]                    status
);
    import tsr_pkg::*;

    logic [DATA_W-1:0] src_num_reg, tgt_num_reg;
    logic [DATA_W-2:0] src_den_reg, tgt_den_reg;
    logic [1:0]        mode_reg;

    logic [DATA_W-1:0] sn_reg, tn_reg, sd_reg, td_reg, stamp_mag_reg;
    logic              sn_neg_reg, tn_neg_reg, st_neg_reg;
    logic [DATA_W-1:0] gn_reg, gd_reg, mul_reg, dvs_reg;

    logic [DATA_W-1:0] ga_reg, gb_reg;
    logic [GK_W-1:0]   gk_reg;

    logic [DATA_W-1:0] drem_reg, dquot_reg, dlo_reg, ddiv_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [DATA_W-1:0]   ma_reg, mb_reg, pp_reg;
    logic [1:0]          psh_reg;
    logic [2*DATA_W-1:0] acc_reg;
    logic [MCNT_W-1:0]   mcnt_reg;

    logic [DATA_W-1:0] res_stamp_reg, out_stamp_reg;
    status_t           res_status_reg, out_status_reg;

    logic [DATA_W-1:0]   stamp_sx, d_shift, d_sub;
    logic                d_carry, d_take;
    logic [DATA_W/2-1:0] ma_part, mb_part;
    logic [2*DATA_W-1:0] pp_sh;
    logic                chk_neg;
    logic                neg, inc;
    logic [DATA_W-1:0]   half_gap, q_inc;
    unit_t               unit;

    assign unit     = step_unit(cmd.step);
    assign stamp_sx = sext_value(stamp_in);

    // divider step
    assign d_carry = drem_reg[DATA_W-1];
    assign d_shift = {drem_reg[DATA_W-2:0], dlo_reg[DATA_W-1]};
    assign d_take  = d_carry || (d_shift >= ddiv_reg);
    assign d_sub   = d_shift - ddiv_reg;

    // multiplier partial product select
    assign ma_part = mcnt_reg[0] ? ma_reg[DATA_W-1:DATA_W/2] : ma_reg[DATA_W/2-1:0];
    assign mb_part = mcnt_reg[1] ? mb_reg[DATA_W-1:DATA_W/2] : mb_reg[DATA_W/2-1:0];

    always_comb
    begin
        case (psh_reg)
            2'd0:    pp_sh = {{DATA_W{1'b0}}, pp_reg};
            2'd1:    pp_sh = {{DATA_W{1'b0}}, pp_reg} << (DATA_W / 2);
            default: pp_sh = {{DATA_W{1'b0}}, pp_reg} << DATA_W;
        endcase
    end

    // status back to the controller
    assign chk_neg = (cmd.step == STEP_MUL_M) ? sn_neg_reg : tn_neg_reg;

    always_comb
    begin
        case (unit)
            UNIT_GCD: stat.done = (ga_reg == gb_reg);
            UNIT_MUL: stat.done = (mcnt_reg == MUL_DONE);
            default:  stat.done = (dcnt_reg == '0);
        endcase
        stat.zero_tgt  = (tgt_num_reg == '0);
        stat.zero_src  = (src_num_reg == '0);
        stat.chk_ovf   = (acc_reg[2*DATA_W-1:DATA_W] != '0) ||
                         (chk_neg ? (acc_reg[DATA_W-1:0] > MAG_LIM) : acc_reg[DATA_W-1]);
        stat.quot_wide = (acc_reg[2*DATA_W-1:DATA_W] >= dvs_reg);
    end

    // rounding
    assign neg      = st_neg_reg ^ sn_neg_reg ^ tn_neg_reg;
    assign half_gap = dvs_reg - drem_reg;

    always_comb
    begin
        case (round_t'(mode_reg))
            RND_DOWN:    inc = neg && (drem_reg != '0);
            RND_UP:      inc = !neg && (drem_reg != '0);
            RND_NEAREST: inc = (drem_reg >= half_gap);
            default:     inc = 1'b0;
        endcase
    end

    assign q_inc = dquot_reg + DATA_W'(inc);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_num_reg <= DATA_W'(1);
            src_den_reg <= (DATA_W-1)'(1);
            tgt_num_reg <= DATA_W'(1);
            tgt_den_reg <= (DATA_W-1)'(1);
            mode_reg    <= RND_ZERO;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_NUM:    src_num_reg <= cfg_data;
                REG_SRC_DEN:    src_den_reg <= cfg_data[DATA_W-2:0];
                REG_TGT_NUM:    tgt_num_reg <= cfg_data;
                REG_TGT_DEN:    tgt_den_reg <= cfg_data[DATA_W-2:0];
                REG_ROUND_MODE: mode_reg    <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                st_neg_reg    <= stamp_sx[DATA_W-1];
                stamp_mag_reg <= abs_mag(stamp_sx);
                sn_neg_reg    <= src_num_reg[DATA_W-1];
                tn_neg_reg    <= tgt_num_reg[DATA_W-1];
                sn_reg        <= abs_mag(src_num_reg);
                tn_reg        <= abs_mag(tgt_num_reg);
                sd_reg        <= (src_den_reg == '0) ? DATA_W'(1) : {1'b0, src_den_reg};
                td_reg        <= (tgt_den_reg == '0) ? DATA_W'(1) : {1'b0, tgt_den_reg};
            end
            OP_START:
            begin
                case (unit)
                    UNIT_GCD:
                    begin
                        gk_reg <= '0;
                        if (cmd.step == STEP_GCD_NUM)
                        begin
                            ga_reg <= sn_reg;
                            gb_reg <= tn_reg;
                        end
                        else
                        begin
                            ga_reg <= sd_reg;
                            gb_reg <= td_reg;
                        end
                    end
                    UNIT_MUL:
                    begin
                        acc_reg  <= '0;
                        mcnt_reg <= '0;
                        case (cmd.step)
                            STEP_MUL_M:
                            begin
                                ma_reg <= sn_reg;
                                mb_reg <= td_reg;
                            end
                            STEP_MUL_D:
                            begin
                                ma_reg <= sd_reg;
                                mb_reg <= tn_reg;
                            end
                            default:
                            begin
                                ma_reg <= stamp_mag_reg;
                                mb_reg <= mul_reg;
                            end
                        endcase
                    end
                    default:
                    begin
                        dcnt_reg  <= DCNT_W'(DIV_STEPS);
                        dquot_reg <= '0;
                        drem_reg  <= '0;
                        case (cmd.step)
                            STEP_DIV_SN:
                            begin
                                dlo_reg  <= sn_reg;
                                ddiv_reg <= gn_reg;
                            end
                            STEP_DIV_TN:
                            begin
                                dlo_reg  <= tn_reg;
                                ddiv_reg <= gn_reg;
                            end
                            STEP_DIV_SD:
                            begin
                                dlo_reg  <= sd_reg;
                                ddiv_reg <= gd_reg;
                            end
                            STEP_DIV_TD:
                            begin
                                dlo_reg  <= td_reg;
                                ddiv_reg <= gd_reg;
                            end
                            default:
                            begin
                                drem_reg <= acc_reg[2*DATA_W-1:DATA_W];
                                dlo_reg  <= acc_reg[DATA_W-1:0];
                                ddiv_reg <= dvs_reg;
                            end
                        endcase
                    end
                endcase
            end
            OP_STEP:
            begin
                case (unit)
                    UNIT_GCD:
                    begin
                        if (ga_reg != gb_reg)
                        begin
                            if (!ga_reg[0] && !gb_reg[0])
                            begin
                                ga_reg <= ga_reg >> 1;
                                gb_reg <= gb_reg >> 1;
                                gk_reg <= gk_reg + GK_W'(1);
                            end
                            else if (!ga_reg[0])
                                ga_reg <= ga_reg >> 1;
                            else if (!gb_reg[0])
                                gb_reg <= gb_reg >> 1;
                            else if (ga_reg > gb_reg)
                                ga_reg <= ga_reg - gb_reg;
                            else
                                gb_reg <= gb_reg - ga_reg;
                        end
                    end
                    UNIT_MUL:
                    begin
                        if (mcnt_reg != MUL_DONE)
                        begin
                            if (mcnt_reg != MUL_LAST)
                            begin
                                pp_reg  <= DATA_W'(ma_part * mb_part);
                                psh_reg <= 2'(mcnt_reg[0]) + 2'(mcnt_reg[1]);
                            end
                            if (mcnt_reg != '0)
                                acc_reg <= acc_reg + pp_sh;
                            mcnt_reg <= mcnt_reg + MCNT_W'(1);
                        end
                    end
                    default:
                    begin
                        if (dcnt_reg != '0)
                        begin
                            drem_reg  <= d_take ? d_sub : d_shift;
                            dquot_reg <= {dquot_reg[DATA_W-2:0], d_take};
                            dlo_reg   <= dlo_reg << 1;
                            dcnt_reg  <= dcnt_reg - DCNT_W'(1);
                        end
                    end
                endcase
            end
            OP_WB:
            begin
                case (cmd.step)
                    STEP_GCD_NUM: gn_reg  <= ga_reg << gk_reg;
                    STEP_GCD_DEN: gd_reg  <= ga_reg << gk_reg;
                    STEP_DIV_SN:  sn_reg  <= dquot_reg;
                    STEP_DIV_TN:  tn_reg  <= dquot_reg;
                    STEP_DIV_SD:  sd_reg  <= dquot_reg;
                    STEP_DIV_TD:  td_reg  <= dquot_reg;
                    STEP_MUL_M:   mul_reg <= acc_reg[DATA_W-1:0];
                    STEP_MUL_D:   dvs_reg <= acc_reg[DATA_W-1:0];
                    default:      ;
                endcase
            end
            OP_FIN:
            begin
                if (inc && (&dquot_reg))
                begin
                    res_stamp_reg  <= '0;
                    res_status_reg <= ST_ROUND_OVF;
                end
                else if (neg ? (q_inc > VAL_LIM) : (q_inc >= VAL_LIM))
                begin
                    res_stamp_reg  <= '0;
                    res_status_reg <= ST_SIGNED_OVF;
                end
                else
                begin
                    res_stamp_reg  <= neg ? (~q_inc + DATA_W'(1)) : q_inc;
                    res_status_reg <= ST_OK;
                end
            end
            OP_ERR:
            begin
                res_stamp_reg  <= '0;
                res_status_reg <= cmd.code;
            end
            OP_EMIT:
            begin
                out_stamp_reg  <= res_stamp_reg;
                out_status_reg <= res_status_reg;
            end
            default: ;
        endcase
    end

    assign stamp_out = out_stamp_reg;
    assign status    = out_status_reg;

endmodule

// ===== rtl/core/timestamp_time_base_rescaler_unit.sv =====
// A zero source or target numerator skips the computation and goes straight to the result.
// Otherwise the time is set by the two binary gcd loops (one bit or one subtract per cycle),
// five 64-step passes through the shared restoring divider and three multiplies of four partial products.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: rst_n asynchronous, clears control state and loads both bases to 1/1, mode 0.
module timestamp_time_base_rescaler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // [63:0] stamp_in
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [71:0]                   m_axis_tdata,  // [63:0] stamp_out, [66:64] status
    input  logic                          cfg_we,
    input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsr_pkg::DATA_W-1:0]    cfg_data
);
    import tsr_pkg::*;

    `include "timestamp_time_base_rescaler_unit_defines.svh"

    tsr_cmd_t          cmd;
    tsr_stat_t         stat;
    logic [DATA_W-1:0] stamp_out;
    logic [2:0]        status;

    tsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tsr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .stamp_in  (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stamp_out (stamp_out),
        .status    (status)
    );

    assign m_axis_tdata = {5'b0, status, stamp_out};

    `TSR_ASSERT_SAME(a_err_zero, m_axis_tvalid && (m_axis_tdata[66:64] != 3'd0), m_axis_tdata[63:0] == 64'd0, "error result with nonzero stamp")
    `TSR_ASSERT_SAME(a_status_range, m_axis_tvalid, m_axis_tdata[66:64] != 3'd7, "undefined status code")
    `TSR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

endmodule

// ===== verif/timestamp_time_base_rescaler_unit_test.sv =====
// Testbench for the timestamp time-base rescaler: directed and random requests against a predictor
`timescale 1ns / 100ps

module timestamp_time_base_rescaler_unit_test;
    import tsr_pkg::*;

    typedef struct packed {
        logic [63:0] stamp;
        status_t     code;
    } rescaled_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    logic [63:0] src_num, tgt_num;
    logic [62:0] src_den, tgt_den;
    round_t      rnd;

    rescaled_t   pending[$];
    int          n_err = 0;
    int          n_req = 0;
    int          n_resp = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    bit          done = 1'b0;

    always #5 clk = ~clk;

    timestamp_time_base_rescaler_unit i_dut (.*);

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] gcd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic bit fits(input logic [63:0] a, input logic [63:0] b, input bit neg,
                                output logic [63:0] p);
        logic [127:0] w;
        w = a * 128'(b);
        p = w[63:0];
        if (w[127:64] != 0)
            return 0;
        return neg ? (p <= 64'h8000_0000_0000_0000) : (p <= 64'h7FFF_FFFF_FFFF_FFFF);
    endfunction

    function automatic rescaled_t rescale(input logic [63:0] stamp);
        rescaled_t r;
        logic [63:0] sd, td, sn, tn, gn, gd, m, d, q, rem;
        logic [127:0] prod;
        bit neg, inc;
        r.stamp = '0;
        r.code = ST_OK;
        sd = src_den ? {1'b0, src_den} : 64'd1;
        td = tgt_den ? {1'b0, tgt_den} : 64'd1;
        sn = mag(src_num);
        tn = mag(tgt_num);
        inc = 0;
        if (tgt_num == 0)
        begin
            r.code = ST_ZERO_TARGET;
            return r;
        end
        if (src_num == 0)
            return r;
        gn = gcd(sn, tn);
        gd = gcd(sd, td);
        if (!fits(sn / gn, td / gd, src_num[63], m))
        begin
            r.code = ST_MUL_OVF;
            return r;
        end
        if (!fits(sd / gd, tn / gn, tgt_num[63], d))
        begin
            r.code = ST_DIV_OVF;
            return r;
        end
        neg = stamp[63] ^ src_num[63] ^ tgt_num[63];
        prod = mag(stamp) * 128'(m);
        if (prod[127:64] >= d)
        begin
            r.code = ST_QUOT_WIDE;
            return r;
        end
        q = 64'(prod / d);
        rem = 64'(prod % d);
        case (rnd)
            RND_DOWN:    inc = neg && rem != 0;
            RND_UP:      inc = !neg && rem != 0;
            RND_NEAREST: inc = rem >= d - rem;
            default:     inc = 0;
        endcase
        if (inc)
        begin
            if (q == '1)
            begin
                r.code = ST_ROUND_OVF;
                return r;
            end
            q++;
        end
        if (neg ? (q > 64'h8000_0000_0000_0000) : (q > 64'h7FFF_FFFF_FFFF_FFFF))
        begin
            r.code = ST_SIGNED_OVF;
            return r;
        end
        r.stamp = neg ? -q : q;
        return r;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SRC_NUM: src_num = val;
            REG_SRC_DEN: src_den = val[62:0];
            REG_TGT_NUM: tgt_num = val;
            REG_TGT_DEN: tgt_den = val[62:0];
            default:     rnd = round_t'(val[1:0]);
        endcase
    endtask

    task automatic drain();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_bases(input logic [63:0] sn, input logic [63:0] sd,
                             input logic [63:0] tn, input logic [63:0] td, input round_t m);
        drain();
        write_reg(REG_SRC_NUM, sn);
        write_reg(REG_SRC_DEN, sd);
        write_reg(REG_TGT_NUM, tn);
        write_reg(REG_TGT_DEN, td);
        write_reg(REG_ROUND_MODE, 64'(m));
    endtask

    task automatic send(input logic [63:0] stamp);
        while (!calm && $urandom_range(99) < 21)
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stamp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending.push_back(rescale(stamp));
        n_req++;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = 64'($signed(v[15:0]));
            1: v = 64'($signed(v[31:0]));
            2: v = v >> $urandom_range(63);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rand_num();
        logic [63:0] v;
        case ($urandom_range(9))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            2: v = {$urandom, $urandom};
            3, 4: v = 64'($signed(16'($urandom)));
            default: v = 64'($urandom_range(100000) + 1);
        endcase
        if (v != 64'h8000_0000_0000_0000 && $urandom_range(1))
            v = -v;
        return v;
    endfunction

    function automatic logic [63:0] rand_den();
        case ($urandom_range(7))
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return {$urandom, $urandom} >> 1;
            2: return {1'b1, 63'd0} | 64'($urandom_range(1000));
            default: return 64'($urandom_range(100000) + 1);
        endcase
    endfunction

    task automatic test_defaults();
        send(64'd0);
        send(64'h7FFF_FFFF_FFFF_FFFF);
        send(64'h8000_0000_0000_0000);
        send(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_special_cases();
        set_bases(64'd0, 64'd3, 64'd7, 64'd5, RND_ZERO);
        send(64'd12345);
        set_bases(64'd3, 64'd1, 64'd0, 64'd5, RND_ZERO);
        send(64'd12345);
        set_bases(64'd1, 64'd0, 64'd1, 64'd0, RND_ZERO);
        send(-64'd99);
        set_bases(64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 64'd1, 64'd3, RND_ZERO);
        send(64'd1);
        set_bases(64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE, 64'd1, RND_ZERO);
        send(64'd1);
        set_bases(64'h8000_0000_0000_0000, 64'd1, 64'd1, 64'd1, RND_ZERO);
        send(64'd1);
        send(64'd2);
        send(-64'd1);
        set_bases(64'd6, 64'd4, 64'd9, 64'd10, RND_ZERO);
        send(64'd1001);
    endtask

    task automatic test_rounding();
        set_bases(64'd1, 64'd1, 64'd2, 64'd1, RND_ZERO);
        for (int m = 0; m < 4; m++)
        begin
            set_bases(64'd1, 64'd1, 64'd2, 64'd1, round_t'(m));
            send(64'd5);
            send(-64'd5);
            send(64'h7FFF_FFFF_FFFF_FFFF);
            send(64'h8000_0000_0000_0000);
        end
        set_bases(64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 64'h7FFF_FFFF_FFFF_FFFE, 64'd1, RND_UP);
        send(64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_random(input int total);
        int k;
        k = 0;
        while (k < total)
        begin
            set_bases(rand_num(), rand_den(), ($urandom_range(30) == 0) ? 64'd0 : rand_num(),
                      rand_den(), round_t'($urandom_range(3)));
            calm = ($urandom_range(7) == 0);
            repeat ($urandom_range(40, 10))
            begin
                send(rand64());
                k++;
            end
            calm = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        rescaled_t want;
        m_axis_tready <= calm || ($urandom_range(99) >= 21);
        if (m_axis_tvalid && m_axis_tready)
        begin
            n_resp++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result stamp=%h status=%0d", $time,
                         m_axis_tdata[63:0], m_axis_tdata[66:64]);
                n_err++;
            end
            else
            begin
                want = pending.pop_front();
                if (m_axis_tdata[63:0] !== want.stamp || m_axis_tdata[66:64] !== want.code)
                begin
                    $display("%0t: expected stamp=%h status=%0d, actual stamp=%h status=%0d",
                             $time, want.stamp, want.code, m_axis_tdata[63:0],
                             m_axis_tdata[66:64]);
                    n_err++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        src_num = 64'd1;
        src_den = 63'd1;
        tgt_num = 64'd1;
        tgt_den = 63'd1;
        rnd = RND_ZERO;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_special_cases();
        test_rounding();
        drain();
        test_random(1950);
        drain();
        repeat (800) @(posedge clk);
        done = 1'b1;
        $display("Covered %0d requests, %0d results: zero bases, overflow codes, all rounding",
                 n_req, n_resp);
        $display("modes and random bases with random idle on both sides.");
        if (n_err == 0 && pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== timestamp_time_base_rescaler_unit.f =====
+incdir+rtl/core
rtl/core/tsr_pkg.sv
rtl/core/tsr_ctrl.sv
rtl/core/tsr_datapath.sv
rtl/core/timestamp_time_base_rescaler_unit.sv
verif/timestamp_time_base_rescaler_unit_test.sv
